>>> src/att_pkg.sv
package att_pkg;

  // table geometry
  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned NUM_W   = 31;
  localparam int unsigned USE_W   = 40;
  localparam int unsigned TOT_W   = 64;
  localparam int unsigned ICPT_W  = 32;

  localparam int unsigned IN_DATA_W  = ADDR_W + SIZE_W;
  localparam int unsigned OUT_DATA_W = ST_W + SLOT_W + NUM_W + USE_W + USE_W + TOT_W;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_INTERCEPT = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_NULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND  = 3'd4;

  // action codes
  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // intercept register reset: disabled
  localparam logic [ICPT_W-1:0] ICPT_RESET = '1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } att_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } att_sts_t;

endpackage

>>> src/att_ctrl.sv
module att_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  att_pkg::att_sts_t sts_i,
  output att_pkg::att_cmd_t cmd_o
);
  import att_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/att_dp.sv
module att_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  att_pkg::att_cmd_t             cmd_i,
  output att_pkg::att_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [att_pkg::ICPT_W-1:0]    cfg_wdata_i,
  input  logic                          in_action_i,
  input  logic [att_pkg::ADDR_W-1:0]    in_address_i,
  input  logic [att_pkg::SIZE_W-1:0]    in_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [att_pkg::ST_W-1:0]      out_status_o,
  output logic [att_pkg::SLOT_W-1:0]    out_slot_o,
  output logic [att_pkg::NUM_W-1:0]     out_num_o,
  output logic [att_pkg::USE_W-1:0]     out_usage_o,
  output logic [att_pkg::USE_W-1:0]     out_peak_o,
  output logic [att_pkg::TOT_W-1:0]     out_total_o
);
  import att_pkg::*;

  // table storage
  logic [ADDR_W-1:0] addr_mem [ENTRIES];
  logic [SIZE_W-1:0] size_mem [ENTRIES];
  logic [ENTRIES-1:0] active_q, active_d;

  // held item
  logic              act_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] size_q;

  // running statistics
  logic [ICPT_W-1:0] icpt_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [NUM_W-1:0]  cnt_q, cnt_d;
  logic [USE_W-1:0]  now_q, now_d;
  logic [USE_W-1:0]  peak_q, peak_d;
  logic [TOT_W-1:0]  tot_q, tot_d;

  // scan pipeline
  logic [CNT_W-1:0]  issue_idx_q;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [SIZE_W-1:0] rd_size_q;
  logic              found_q;
  logic [IDX_W-1:0]  found_idx_q;
  logic [SIZE_W-1:0] found_size_q;

  // output register
  logic              out_valid_q;
  logic [ST_W-1:0]   out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [NUM_W-1:0]  out_num_q;
  logic [USE_W-1:0]  out_usage_q;
  logic [USE_W-1:0]  out_peak_q;
  logic [TOT_W-1:0]  out_total_q;

  logic              issue;
  logic              hit;
  logic              exhausted;
  logic              null_add;
  logic              add_ok;
  logic              mem_we;
  logic [IDX_W-1:0]  slot;
  logic [ST_W-1:0]   status;
  logic [USE_W:0]    now_sum;
  logic [USE_W-1:0]  now_add;
  logic [TOT_W:0]    tot_sum;
  logic [NUM_W-1:0]  cnt_inc;

  // scan control
  assign issue     = cmd_i.scan && (issue_idx_q < used_q);
  assign null_add  = (act_q == ACT_ADD) && (addr_q == '0);
  assign hit       = cmp_vld_q && ((act_q == ACT_RELEASE)
                     ? (active_q[cmp_idx_q] && (rd_addr_q == addr_q))
                     : !active_q[cmp_idx_q]);
  assign exhausted = (issue_idx_q >= used_q) && !cmp_vld_q;

  assign sts_o.scan_done = null_add || hit || exhausted;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // statistics arithmetic
  assign cnt_inc = cnt_q + NUM_W'(1);
  assign now_sum = {1'b0, now_q} + (USE_W + 1)'(size_q);
  assign now_add = now_sum[USE_W] ? '1 : now_sum[USE_W-1:0];
  assign tot_sum = {1'b0, tot_q} + (TOT_W + 1)'(size_q);

  // commit decision
  always_comb begin
    active_d = active_q;
    used_d   = used_q;
    cnt_d    = cnt_q;
    now_d    = now_q;
    peak_d   = peak_q;
    tot_d    = tot_q;
    slot     = '0;
    status   = ST_OK;
    add_ok   = 1'b0;
    priority if (null_add) begin
      status = ST_NULL;
    end else if (act_q == ACT_ADD) begin
      if (found_q) begin
        slot   = found_idx_q;
        add_ok = 1'b1;
      end else if (used_q >= CNT_W'(ENTRIES)) begin
        status = ST_FULL;
      end else begin
        slot   = used_q[IDX_W-1:0];
        used_d = used_q + CNT_W'(1);
        add_ok = 1'b1;
      end
      if (add_ok) begin
        cnt_d          = cnt_inc;
        now_d          = now_add;
        peak_d         = (now_add > peak_q) ? now_add : peak_q;
        tot_d          = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
        active_d[slot] = 1'b1;
        if (!icpt_q[ICPT_W-1] && (icpt_q[NUM_W-1:0] == cnt_inc)) begin
          status = ST_INTERCEPT;
        end
      end
    end else begin
      if (found_q) begin
        slot           = found_idx_q;
        active_d[slot] = 1'b0;
        now_d          = (now_q >= USE_W'(found_size_q))
                         ? now_q - USE_W'(found_size_q) : '0;
      end else begin
        status = ST_NOTFOUND;
      end
    end
  end

  assign mem_we = cmd_i.commit && add_ok;

  // table memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[slot] <= addr_q;
      size_mem[slot] <= size_q;
    end
    rd_addr_q <= addr_mem[issue_idx_q[IDX_W-1:0]];
    rd_size_q <= size_mem[issue_idx_q[IDX_W-1:0]];
  end

  // item and hit payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= in_action_i;
      addr_q <= in_address_i;
      size_q <= in_size_i;
    end
    if (cmd_i.scan && hit && !found_q) begin
      found_idx_q  <= cmp_idx_q;
      found_size_q <= rd_size_q;
    end
    if (issue) begin
      cmp_idx_q <= issue_idx_q[IDX_W-1:0];
    end
  end

  // scan control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_idx_q <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
    end else if (cmd_i.load) begin
      issue_idx_q <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_q <= issue && !hit;
      if (issue && !hit) begin
        issue_idx_q <= issue_idx_q + CNT_W'(1);
      end
      if (hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // table state and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icpt_q   <= ICPT_RESET;
      active_q <= '0;
      used_q   <= '0;
      cnt_q    <= '0;
      now_q    <= '0;
      peak_q   <= '0;
      tot_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        icpt_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        active_q <= active_d;
        used_q   <= used_d;
        cnt_q    <= cnt_d;
        now_q    <= now_d;
        peak_q   <= peak_d;
        tot_q    <= tot_d;
      end
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= status;
      out_slot_q   <= SLOT_W'(slot);
      out_num_q    <= cnt_d;
      out_usage_q  <= now_d;
      out_peak_q   <= peak_d;
      out_total_q  <= tot_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_num_o    = out_num_q;
  assign out_usage_o  = out_usage_q;
  assign out_peak_o   = out_peak_q;
  assign out_total_o  = out_total_q;

endmodule

>>> src/allocation_tracking_table_core.sv
// Allocation tracking table.
// Slave stream: one beat per event; tuser selects add (0) or release (1),
// tdata carries the address and the block size. Master stream: one beat per
// event with status, slot, allocation number, current usage, high-water mark
// and saturating total. cfg_we_i writes the intercept allocation number.
// Each event scans the table one slot per cycle through the registered read
// port of the address/size memory: a scan stops at the first matching slot
// or runs through all used slots. An add with a null address skips the
// scan. One event is worked at a time; the next beat can be taken in the
// cycle after the previous result enters the output register.
// Reset clears the active bits, counters and statistics at once and disables
// the intercept; address and size memories are not cleared, an entry is only
// compared once its active bit is set. If the master side stalls, the
// finished result holds in the output register and the following event waits
// after its scan before commit.
module allocation_tracking_table_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [att_pkg::ICPT_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [63:0] address, [95:64] block_size
  input  logic [att_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] action
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] status, [8:3] slot_index, [39:9] allocation_number,
  // [79:40] current_usage, [119:80] high_water, [183:120] total_allocated
  output logic [att_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import att_pkg::*;

  att_cmd_t          cmd;
  att_sts_t          sts;
  logic [ST_W-1:0]   out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [NUM_W-1:0]  out_num;
  logic [USE_W-1:0]  out_usage;
  logic [USE_W-1:0]  out_peak;
  logic [TOT_W-1:0]  out_total;

  // sequencer
  att_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, statistics and output register
  att_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_action_i  (s_axis_tuser),
    .in_address_i (s_axis_tdata[ADDR_W-1:0]),
    .in_size_i    (s_axis_tdata[ADDR_W +: SIZE_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_slot_o   (out_slot),
    .out_num_o    (out_num),
    .out_usage_o  (out_usage),
    .out_peak_o   (out_peak),
    .out_total_o  (out_total)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {out_total, out_peak, out_usage, out_num, out_slot, out_status};

endmodule

>>> dv/allocation_tracking_table_core_tb.sv
`timescale 1ns / 1ps

module allocation_tracking_table_core_tb;
  import att_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 140;
  localparam int DRAIN_CYCLES   = 80;

  typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} load_mix_e;

  typedef struct {
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } alloc_req_t;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [NUM_W-1:0]  num;
    logic [USE_W-1:0]  usage;
    logic [USE_W-1:0]  peak;
    logic [TOT_W-1:0]  total;
  } alloc_rsp_t;

  // dut ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [ICPT_W-1:0]     cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // stimulus and scoreboard
  alloc_req_t        req_q[$];
  alloc_rsp_t        rsp_q[$];
  logic [ADDR_W-1:0] addr_pool[$];
  int                pushed = 0;
  int                accepted = 0;
  int                errors = 0;
  int                idle_cycles = 0;
  int                idle_odds = 4;
  int                gap_left = 0;
  int                stall_left = 0;
  logic              in_beat = 1'b0;

  // shadow of the allocation table
  logic [ADDR_W-1:0] tbl_addr[ENTRIES];
  logic [SIZE_W-1:0] tbl_size[ENTRIES];
  logic              tbl_live[ENTRIES];
  int unsigned       slots_seen;
  logic [NUM_W-1:0]  alloc_cnt;
  logic [USE_W-1:0]  usage_cur;
  logic [USE_W-1:0]  usage_max;
  logic [TOT_W-1:0]  usage_sum;
  logic [ICPT_W-1:0] icpt_num;

  allocation_tracking_table_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one event to the shadow table and return the result it should give
  function automatic alloc_rsp_t track_request(alloc_req_t rq);
    alloc_rsp_t      rs;
    int unsigned     hit;
    logic [USE_W:0]  use_sum;
    logic [TOT_W:0]  tot_sum;
    hit       = ENTRIES;
    rs.status = ST_OK;
    rs.slot   = '0;
    if (rq.act == ACT_ADD) begin
      if (rq.addr == '0) begin
        rs.status = ST_NULL;
      end else begin
        // first free slot among those used so far
        for (int i = 0; i < slots_seen; i++)
          if (!tbl_live[i] && hit == ENTRIES) hit = i;
        if (hit == ENTRIES && slots_seen >= ENTRIES) begin
          rs.status = ST_FULL;
        end else begin
          if (hit == ENTRIES) begin
            hit = slots_seen;
            slots_seen++;
          end
          alloc_cnt = alloc_cnt + NUM_W'(1);
          use_sum   = {1'b0, usage_cur} + (USE_W + 1)'(rq.size);
          usage_cur = use_sum[USE_W] ? '1 : use_sum[USE_W-1:0];
          if (usage_cur > usage_max) usage_max = usage_cur;
          tot_sum   = {1'b0, usage_sum} + (TOT_W + 1)'(rq.size);
          usage_sum = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
          tbl_live[hit] = 1'b1;
          tbl_addr[hit] = rq.addr;
          tbl_size[hit] = rq.size;
          // negative intercept values never match
          if (!icpt_num[ICPT_W-1] && icpt_num[NUM_W-1:0] == alloc_cnt)
            rs.status = ST_INTERCEPT;
          rs.slot = SLOT_W'(hit);
        end
      end
    end else begin
      // only live slots match a release
      for (int i = 0; i < slots_seen; i++)
        if (tbl_live[i] && tbl_addr[i] == rq.addr && hit == ENTRIES) hit = i;
      if (hit == ENTRIES) begin
        rs.status = ST_NOTFOUND;
      end else begin
        tbl_live[hit] = 1'b0;
        usage_cur = (usage_cur >= USE_W'(tbl_size[hit]))
                    ? usage_cur - USE_W'(tbl_size[hit]) : '0;
        rs.slot = SLOT_W'(hit);
      end
    end
    rs.num   = alloc_cnt;
    rs.usage = usage_cur;
    rs.peak  = usage_max;
    rs.total = usage_sum;
    return rs;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // input capture, prediction, result check and watchdog
  always @(posedge clk_i) begin : monitor
    alloc_req_t rq;
    alloc_rsp_t want;
    logic       out_beat;
    in_beat  = s_axis_tvalid && s_axis_tready && rst_ni;
    out_beat = m_axis_tvalid && m_axis_tready && rst_ni;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) tbl_live[i] = 1'b0;
      slots_seen = 0;
      alloc_cnt  = '0;
      usage_cur  = '0;
      usage_max  = '0;
      usage_sum  = '0;
      icpt_num   = ICPT_RESET;
    end else begin
      if (cfg_we_i) icpt_num = cfg_wdata_i;
      if (in_beat) begin
        rq.act  = s_axis_tuser;
        rq.addr = s_axis_tdata[ADDR_W-1:0];
        rq.size = s_axis_tdata[ADDR_W +: SIZE_W];
        rsp_q.push_back(track_request(rq));
        accepted++;
      end
      if (out_beat) begin
        if (rsp_q.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          want = rsp_q.pop_front();
          check_field("status", 64'(want.status), 64'(m_axis_tdata[2:0]));
          check_field("slot_index", 64'(want.slot), 64'(m_axis_tdata[8:3]));
          check_field("allocation_number", 64'(want.num), 64'(m_axis_tdata[39:9]));
          check_field("current_usage", 64'(want.usage), 64'(m_axis_tdata[79:40]));
          check_field("high_water", 64'(want.peak), 64'(m_axis_tdata[119:80]));
          check_field("total_allocated", want.total, m_axis_tdata[183:120]);
        end
      end
      idle_cycles = (in_beat || out_beat) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** allocation_tracking_table_core: FAILED **");
        $finish;
      end
    end
  end

  // request driver with random gaps
  always @(negedge clk_i) begin : driver
    alloc_req_t rq;
    if (!s_axis_tvalid || in_beat) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (req_q.size() > 0) begin
        rq = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.act;
        s_axis_tdata  <= {rq.size, rq.addr};
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          gap_left = $urandom_range(1, 5);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure in bursts
  always @(negedge clk_i) begin : sink
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        stall_left = $urandom_range(1, 5);
    end
  end

  task automatic queue_request(logic act, logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
    alloc_req_t rq;
    rq.act  = act;
    rq.addr = addr;
    rq.size = size;
    req_q.push_back(rq);
    pushed++;
  endtask

  // sender holds off until every result is back
  task automatic wait_idle();
    while (req_q.size() != 0 || accepted != pushed || rsp_q.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_intercept(logic [ICPT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // sizes lean toward the extremes now and then
  function automatic logic [SIZE_W-1:0] pick_size();
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'(1) << $urandom_range(0, SIZE_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // one random event: adds feed the address pool, releases mostly draw from it
  task automatic queue_random(load_mix_e mix);
    int                add_pct;
    int                pick;
    logic [ADDR_W-1:0] addr;
    add_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 20 : 50;
    if ($urandom_range(0, 99) < add_pct) begin
      if ($urandom_range(0, 99) < 3) begin
        addr = '0;
      end else if (addr_pool.size() > 0 && $urandom_range(0, 9) == 0) begin
        addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        addr_pool.push_back(addr);
      end else begin
        addr = {$urandom, $urandom};
        addr_pool.push_back(addr);
      end
      queue_request(ACT_ADD, addr, pick_size());
    end else begin
      if (addr_pool.size() > 0 && $urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, addr_pool.size() - 1);
        addr = addr_pool[pick];
        addr_pool.delete(pick);
      end else begin
        addr = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
      end
      queue_request(ACT_RELEASE, addr, $urandom);
    end
  endtask

  initial begin : stimulus
    load_mix_e         phase_mix[PHASES];
    logic [ICPT_W-1:0] icpt;
    phase_mix = '{MIX_EVEN, MIX_FILL, MIX_EVEN, MIX_DRAIN,
                  MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_FILL};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty-table release, null add, extremes, duplicates, slot reuse
    queue_request(ACT_RELEASE, '0, '0);
    queue_request(ACT_ADD, '0, '1);
    queue_request(ACT_ADD, '1, '1);
    queue_request(ACT_ADD, 64'h1, '0);
    queue_request(ACT_ADD, 64'h8000_0000_0000_0000, 32'h8000_0000);
    queue_request(ACT_ADD, '1, 32'd5);
    queue_request(ACT_RELEASE, '1, '0);
    queue_request(ACT_RELEASE, '1, '1);
    queue_request(ACT_RELEASE, '1, '0);
    queue_request(ACT_ADD, 64'h5555_AAAA_5555_AAAA, 32'h5555_AAAA);
    queue_request(ACT_RELEASE, 64'h1, '1);
    queue_request(ACT_RELEASE, 64'h1, '0);
    queue_request(ACT_ADD, 64'hAAAA_5555_AAAA_5555, 32'hAAAA_5555);
    queue_request(ACT_RELEASE, 64'h8000_0000_0000_0000, '0);
    queue_request(ACT_RELEASE, 64'h5555_AAAA_5555_AAAA, '0);
    queue_request(ACT_RELEASE, 64'hAAAA_5555_AAAA_5555, '0);
    wait_idle();

    // random phases, intercept changed between them while idle
    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0:       icpt = ICPT_W'(alloc_cnt) + 5;
        1:       icpt = 32'h7FFF_FFFF;
        2:       icpt = ICPT_W'(alloc_cnt) + 20;
        3:       icpt = 32'h8000_0000;
        4:       icpt = ICPT_RESET;
        5:       icpt = '0;
        6:       icpt = ICPT_W'(alloc_cnt) + 1;
        default: icpt = ICPT_W'(alloc_cnt) + 30;
      endcase
      set_intercept(icpt);
      idle_odds = (p == 2 || p == PHASES - 1) ? 0 : $urandom_range(2, 8);
      for (int n = 0; n < PHASE_ITEMS; n++) queue_random(phase_mix[p]);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("** allocation_tracking_table_core: PASSED **");
    end else begin
      $display("** allocation_tracking_table_core: FAILED **");
    end
    $finish;
  end

endmodule
